FILE: design/mrt_pkg.sv
// ---------------------------------------------------------------------------
// mrt_pkg: shared types and constants of the memory region table
// Holds the table depth, the entry layout, the request codes and the
// controller state type.
// ---------------------------------------------------------------------------
package mrt_pkg;

  // Number of regions that the table can hold.
  localparam int MaxEntries = 16;
  // Counter width that can hold MaxEntries itself.
  localparam int CntW = $clog2(MaxEntries + 1);
  // Index width into the table.
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  // Request codes.
  localparam logic OpInsert = 1'b0;
  localparam logic OpCheck  = 1'b1;

  // Memory map type code of an available region.
  localparam logic [31:0] TypeAvailable = 32'd1;

  // One stored region.
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
    logic        reserved;
  } mrt_entry_t;

  localparam int EntryW = $bits(mrt_entry_t);

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_DONE
  } mrt_state_e;

endpackage

FILE: design/mrt_ram.sv
// ---------------------------------------------------------------------------
// mrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ---------------------------------------------------------------------------
module mrt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/mrt_overlap.sv
// ---------------------------------------------------------------------------
// mrt_overlap: reserved-range overlap test for one stored entry
// Half-open ranges; ends are taken in 65 bits so a wrapping range
// extends to the top of the address space.
// ---------------------------------------------------------------------------
module mrt_overlap (
  input  logic [63:0]              addr_i,
  input  logic [63:0]              len_i,
  input  mrt_pkg::mrt_entry_t      entry_i,
  output logic                     hit_o
);
  import mrt_pkg::*;

  logic [64:0] check_end;
  logic [64:0] entry_end;
  logic        addr_below;
  logic        entry_below;

  // Both ends in 65 bits.
  assign check_end = {1'b0, addr_i} + {1'b0, len_i};
  assign entry_end = {1'b0, entry_i.start} + {1'b0, entry_i.length};

  // Each start must lie below the other range's end.
  assign addr_below  = {1'b0, addr_i} < entry_end;
  assign entry_below = {1'b0, entry_i.start} < check_end;

  assign hit_o = entry_i.reserved && addr_below && entry_below;

endmodule

FILE: design/memory_region_table_overlap_top.sv
// ---------------------------------------------------------------------------
// memory_region_table_overlap_top: memory region table with overlap check
// Stores physical memory regions and answers whether a range overlaps a
// reserved one, while tracking the highest end address and available bytes.
// ---------------------------------------------------------------------------
// Usage:
// A request on the in_* channel is either an insert (op 0) or a check
// (op 1). Every request yields exactly one response on the out_* channel.
// An insert writes the region into the entry memory at the fill count and
// updates the saturating maximum end address and, for an available region,
// the available byte total; an insert into a full table is dropped and
// reported through table_full_o. A check reads the stored entries one per
// cycle from the entry memory (registered read, reads pipelined) and stops
// at the first hit. One request is in flight at a time: the next request is
// taken the cycle after the response is loaded. The response sits in an
// output register; a finished response waits in the controller, with the
// input held off, while the receiver stalls and the register is still full.
// Reset clears the fill count, the totals and the output valid; entry memory
// contents need no clearing since only filled entries are read.
// ---------------------------------------------------------------------------
module memory_region_table_overlap_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] region_address_i,
  input  logic [63:0] region_length_i,
  input  logic [31:0] region_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        overlaps_reserved_o,
  output logic [63:0] highest_end_address_o,
  output logic [63:0] available_bytes_o,
  output logic        table_full_o
);
  import mrt_pkg::*;

  mrt_state_e    state_q, state_d;

  // Latched request.
  logic          op_q;
  logic [63:0]   addr_q;
  logic [63:0]   len_q;
  logic [31:0]   type_q;

  // Table bookkeeping.
  logic [CntW-1:0] count_q;
  logic [63:0]     max_end_q;
  logic [63:0]     total_q;

  // Scan control.
  logic [CntW-1:0] issue_q;
  logic            cmp_vld_q;
  logic            hit_q;
  logic            full_q;

  // Output register.
  logic          out_valid_q;
  logic          res_hit_q;
  logic          res_full_q;
  logic [63:0]   res_max_q;
  logic [63:0]   res_total_q;

  logic          in_fire;
  logic          ram_we;
  logic          ram_re;
  logic          load_out;
  logic          entry_hit;
  logic          table_is_full;
  logic          scan_end;
  mrt_entry_t    wr_entry;
  mrt_entry_t    rd_entry;
  logic [EntryW-1:0] rd_data;

  // Insert arithmetic.
  logic [64:0]   end_sum;
  logic [63:0]   end_sat;
  logic [64:0]   total_sum;
  logic [63:0]   total_sat;

  assign in_fire       = in_valid_i && in_ready_o;
  assign table_is_full = count_q >= CntW'(MaxEntries);

  // Saturating end address and available total for an insert.
  assign end_sum   = {1'b0, addr_q} + {1'b0, len_q};
  assign end_sat   = end_sum[64] ? {64{1'b1}} : end_sum[63:0];
  assign total_sum = {1'b0, total_q} + {1'b0, len_q};
  assign total_sat = total_sum[64] ? {64{1'b1}} : total_sum[63:0];

  assign wr_entry.start    = addr_q;
  assign wr_entry.length   = len_q;
  assign wr_entry.reserved = type_q != TypeAvailable;

  // Entry memory.
  mrt_ram #(
    .WIDTH (EntryW),
    .DEPTH (MaxEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_entry = rd_data;

  // Overlap test on the entry just read.
  mrt_overlap u_overlap (
    .addr_i  (addr_q),
    .len_i   (len_q),
    .entry_i (rd_entry),
    .hit_o   (entry_hit)
  );

  // Scan ends on a hit or once every filled entry has been compared.
  assign scan_end = (cmp_vld_q && entry_hit) || (issue_q == count_q && !cmp_vld_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_i == OpCheck) begin
            state_d = (count_q == '0) ? S_DONE : S_SCAN;
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_INS:  state_d = S_DONE;
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_INS:  ram_we     = !table_is_full;
      S_SCAN: ram_re     = (issue_q < count_q) && !hit_q;
      S_DONE: load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_i;
      addr_q <= region_address_i;
      len_q  <= region_length_i;
      type_q <= region_type_i;
    end
  end

  // Table bookkeeping: fill count, maximum end and available total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      max_end_q <= '0;
      total_q   <= '0;
    end else if (ram_we) begin
      count_q <= count_q + CntW'(1);
      if (end_sat > max_end_q) begin
        max_end_q <= end_sat;
      end
      if (type_q == TypeAvailable) begin
        total_q <= total_sat;
      end
    end
  end

  // Scan pointer, compare pipeline and per-request flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      cmp_vld_q <= ram_re;
      if (in_fire) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
        full_q  <= 1'b0;
      end else begin
        if (ram_re) begin
          issue_q <= issue_q + CntW'(1);
        end
        if (cmp_vld_q && entry_hit && state_q == S_SCAN) begin
          hit_q <= 1'b1;
        end
        if (state_q == S_INS && op_q == OpInsert) begin
          full_q <= table_is_full;
        end
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_hit_q   <= hit_q;
      res_full_q  <= full_q;
      res_max_q   <= max_end_q;
      res_total_q <= total_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign overlaps_reserved_o   = res_hit_q;
  assign table_full_o          = res_full_q;
  assign highest_end_address_o = res_max_q;
  assign available_bytes_o     = res_total_q;

endmodule
